// ===== rtl/core/pec15_frame_builder_unit_assert.svh =====
// Assertion macros for the PEC15 frame builder.
// Each use names a label, an antecedent and a consequent; clk and rst are taken
// from the module that uses the macro.
`ifndef PEC15_FRAME_BUILDER_UNIT_ASSERT_SVH
`define PEC15_FRAME_BUILDER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PFB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pec15 frame builder: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define PFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pec15 frame builder: next-cycle check failed");

`endif

// ===== rtl/core/pfb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared constants, types and the CRC15 (poly 0x4599) byte table.
// ----------------------------------------------------------------------------
package pfb_pkg;

  localparam logic [15:0] PEC_SEED  = 16'd16;
  localparam logic [15:0] PEC_POLY  = 16'h4599;
  localparam logic [7:0]  FILL_BYTE = 8'hff;

  typedef logic [15:0] pec_table_t [256];

  // Result of one byte step: new remainder and the two PEC bytes taken from it.
  typedef struct packed {
    logic [15:0] rem_next;
    logic [7:0]  pec_hi;
    logic [7:0]  pec_lo;
  } pec_step_t;

  // Built at elaboration; bit-serial division of (i << 7) over 8 shifts.
  function automatic pec_table_t build_pec_table();
    pec_table_t  tbl;
    logic [15:0] r;
    for (int i = 0; i < 256; i++) begin
      r = {1'b0, i[7:0], 7'b0};
      for (int b = 0; b < 8; b++) begin
        if (r[14]) begin
          r = {r[14:0], 1'b0} ^ PEC_POLY;
        end else begin
          r = {r[14:0], 1'b0};
        end
      end
      tbl[i] = r;
    end
    return tbl;
  endfunction

  localparam pec_table_t PEC_TABLE = build_pec_table();

endpackage

// ===== rtl/core/pfb_crc_step.sv =====
// ----------------------------------------------------------------------------
// pfb_crc_step
// One table step of the PEC15 remainder for one byte, plus the PEC byte split.
// ----------------------------------------------------------------------------
module pfb_crc_step
  import pfb_pkg::*;
(
  input  logic [15:0] rem,
  input  logic [7:0]  data_byte,
  output pec_step_t   step
);

  logic [7:0]  addr;
  logic [15:0] rem_next;

  assign addr     = rem[14:7] ^ data_byte;
  assign rem_next = {rem[7:0], 8'h00} ^ PEC_TABLE[addr];

  assign step.rem_next = rem_next;
  assign step.pec_hi   = rem_next[14:7];
  assign step.pec_lo   = {rem_next[6:0], 1'b0};

endmodule

// ===== rtl/core/pec15_frame_builder_unit.sv =====
// ----------------------------------------------------------------------------
// pec15_frame_builder_unit - PEC15 command-frame byte builder
// Path: an accepted item waits in the input register, then loads the result
//   register, whose slot 0 is the result offered on the port.
// Throughput: 1 item/cycle for filler and mid-group bytes while out_ready is high;
//   a group-end byte holds the output register until its 3 results (byte, PEC high, PEC low) transfer.
// Reset (rst, synchronous): pipeline emptied, PEC remainder reseeded to 16.
// ----------------------------------------------------------------------------
`include "pec15_frame_builder_unit_assert.svh"

module pec15_frame_builder_unit
  import pfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] data_byte,
  input  logic       group_end,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_pec,
  output logic       last_of_run
);

  // Stage 1: accepted item, held until the result register can take it.
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_byte;
  logic       s1_end;
  logic       s1_move;

  // Running PEC remainder, updated when a group byte moves into stage 2.
  logic [15:0] rem;
  logic [15:0] rem_next;
  pec_step_t   step;

  // Stage 2: up to three queued results; slot 0 is the one on the port.
  logic [7:0] slot_byte      [3];
  logic       slot_pec       [3];
  logic [7:0] slot_byte_next [3];
  logic       slot_pec_next  [3];
  logic [1:0] res_cnt;
  logic [1:0] res_cnt_next;
  logic       pop;

  // ---------------------------------------------------------------------------
  // Handshake
  // Stage 1 drains when the result register is empty or its last result is
  // being transferred this cycle, so single-result items stream at full rate.
  // ---------------------------------------------------------------------------
  assign out_valid   = (res_cnt != 2'd0);
  assign pop         = out_valid && out_ready;
  assign s1_move     = s1_valid && ((res_cnt == 2'd0) || ((res_cnt == 2'd1) && out_ready));
  assign in_ready    = !s1_valid || s1_move;

  assign out_byte    = slot_byte[0];
  assign is_pec      = slot_pec[0];
  assign last_of_run = (res_cnt == 2'd1);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= op;
      s1_byte <= data_byte;
      s1_end  <= group_end;
    end
  end

  // ---------------------------------------------------------------------------
  // PEC step between the input register and the result register
  // ---------------------------------------------------------------------------
  pfb_crc_step u_crc_step (
    .rem       (rem),
    .data_byte (s1_byte),
    .step      (step)
  );

  always_comb begin
    rem_next = rem;
    if (s1_move && !s1_op) begin
      // group end reseeds; filler leaves the remainder alone
      rem_next = s1_end ? PEC_SEED : step.rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= PEC_SEED;
    end else begin
      rem <= rem_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: shift out one slot per transfer, load on stage-1 move.
  // A load only happens when the queue is empty or emptying, so it wins.
  // ---------------------------------------------------------------------------
  always_comb begin
    res_cnt_next = res_cnt;
    for (int i = 0; i < 3; i++) begin
      slot_byte_next[i] = slot_byte[i];
      slot_pec_next[i]  = slot_pec[i];
    end

    if (pop) begin
      res_cnt_next      = res_cnt - 2'd1;
      slot_byte_next[0] = slot_byte[1];
      slot_pec_next[0]  = slot_pec[1];
      slot_byte_next[1] = slot_byte[2];
      slot_pec_next[1]  = slot_pec[2];
    end

    if (s1_move) begin
      slot_pec_next[0] = 1'b0;
      slot_pec_next[1] = 1'b1;
      slot_pec_next[2] = 1'b1;
      slot_byte_next[1] = step.pec_hi;
      slot_byte_next[2] = step.pec_lo;
      if (s1_op) begin
        slot_byte_next[0] = FILL_BYTE;
        res_cnt_next      = 2'd1;
      end else begin
        slot_byte_next[0] = s1_byte;
        res_cnt_next      = s1_end ? 2'd3 : 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else begin
      res_cnt <= res_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      slot_byte[i] <= slot_byte_next[i];
      slot_pec[i]  <= slot_pec_next[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a full queue always holds the echoed byte ahead of two PEC bytes
  `PFB_ASSERT_SAME(a_full_queue_layout, res_cnt == 2'd3,
                   !slot_pec[0] && slot_pec[1] && slot_pec[2])
  // group end leaves the seed behind for the next group
  `PFB_ASSERT_NEXT(a_reseed_on_end, s1_move && !s1_op && s1_end, rem == PEC_SEED)
  // filler never touches the remainder
  `PFB_ASSERT_NEXT(a_filler_keeps_rem, s1_move && s1_op, $stable(rem))
  // a PEC byte on the port only follows a group-end load
  `PFB_ASSERT_SAME(a_pec_count, out_valid && is_pec, res_cnt == 2'd1 || res_cnt == 2'd2)

endmodule
